@@ hdl/utf16_to_utf8_transcoder_unit_defines.svh @@
// Assertion macros shared by the transcoder RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define U2U8_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define U2U8_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define U2U8_ASSERT_ALWAYS(label, expr, msg)
`define U2U8_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

@@ hdl/u2u8_pkg.sv @@
`default_nettype none

package u2u8_pkg;

    localparam int JOB_BYTES = 6;
    localparam int JOB_CNT_W = 3;

    localparam logic [7:0] BYTE_EF  = 8'hef;
    localparam logic [7:0] BYTE_BF  = 8'hbf;
    localparam logic [7:0] BYTE_BD  = 8'hbd;
    localparam logic [7:0] LEAD_4   = 8'hf0;
    localparam logic [7:0] LEAD_3   = 8'he0;
    localparam logic [7:0] LEAD_2   = 8'hc0;
    localparam logic [7:0] CONT     = 8'h80;

    localparam logic [5:0]  SURR_HIGH = 6'b110110;
    localparam logic [5:0]  SURR_LOW  = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] LIM_1BYTE = 16'h0080;
    localparam logic [15:0] LIM_2BYTE = 16'h0800;

    // One queued job: the bytes caused by one code unit, lowest entry first.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [JOB_CNT_W-1:0]      count;
        logic                      last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

@@ hdl/u2u8_front.sv @@
`default_nettype none

module u2u8_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // [15:0] code_unit
    input  wire logic                   s_tlast,   // end_of_string
    input  wire u2u8_pkg::queue_status_t q_status,
    output logic                        push,
    output u2u8_pkg::job_t              push_job
);
    import u2u8_pkg::*;

    logic        pending_reg, pending_next;
    logic [9:0]  high_bits_reg, high_bits_next;

    logic        accept;
    logic        is_high, is_low, pair;
    logic [20:0] cp;
    logic [2:0][7:0] sec;
    logic [1:0]  sec_n;
    logic        prefix;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign is_high  = (s_tdata[15:10] == SURR_HIGH);
    assign is_low   = (s_tdata[15:10] == SURR_LOW);
    assign pair     = pending_reg && is_low;
    assign prefix   = pending_reg && !is_low;
    assign cp       = SUPP_BASE + {1'b0, high_bits_reg, s_tdata[9:0]};

    // Bytes for the unit itself, ignoring any held high surrogate
    always_comb
    begin
        sec   = '0;
        sec_n = 2'd0;
        if (is_high && !s_tlast)
        begin
            sec_n = 2'd0;
        end
        else if (is_high || is_low)
        begin
            sec[0] = BYTE_EF;
            sec[1] = BYTE_BF;
            sec[2] = BYTE_BD;
            sec_n  = 2'd3;
        end
        else if (s_tdata < LIM_1BYTE)
        begin
            sec[0] = s_tdata[7:0];
            sec_n  = 2'd1;
        end
        else if (s_tdata < LIM_2BYTE)
        begin
            sec[0] = LEAD_2 | {3'b000, s_tdata[10:6]};
            sec[1] = CONT | {2'b00, s_tdata[5:0]};
            sec_n  = 2'd2;
        end
        else
        begin
            sec[0] = LEAD_3 | {4'b0000, s_tdata[15:12]};
            sec[1] = CONT | {2'b00, s_tdata[11:6]};
            sec[2] = CONT | {2'b00, s_tdata[5:0]};
            sec_n  = 2'd3;
        end
    end

    always_comb
    begin
        push_job      = '0;
        push_job.last = s_tlast;
        if (pair)
        begin
            push_job.data[0] = LEAD_4 | {5'b00000, cp[20:18]};
            push_job.data[1] = CONT | {2'b00, cp[17:12]};
            push_job.data[2] = CONT | {2'b00, cp[11:6]};
            push_job.data[3] = CONT | {2'b00, cp[5:0]};
            push_job.count   = 3'd4;
        end
        else if (prefix)
        begin
            // replacement for the held surrogate goes out first
            push_job.data[0] = BYTE_EF;
            push_job.data[1] = BYTE_BF;
            push_job.data[2] = BYTE_BD;
            push_job.data[3] = sec[0];
            push_job.data[4] = sec[1];
            push_job.data[5] = sec[2];
            push_job.count   = 3'd3 + {1'b0, sec_n};
        end
        else
        begin
            push_job.data[0] = sec[0];
            push_job.data[1] = sec[1];
            push_job.data[2] = sec[2];
            push_job.count   = {1'b0, sec_n};
        end
    end

    assign push = accept && (push_job.count != '0);

    always_comb
    begin
        pending_next   = pending_reg;
        high_bits_next = high_bits_reg;
        if (accept)
        begin
            pending_next   = is_high && !s_tlast;
            high_bits_next = s_tdata[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        high_bits_reg <= high_bits_next;
    end

endmodule

`default_nettype wire

@@ hdl/u2u8_queue.sv @@
`default_nettype none
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module u2u8_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire u2u8_pkg::job_t          push_job,
    input  wire logic                    pop,
    output u2u8_pkg::job_t               pop_job,
    output u2u8_pkg::queue_status_t      status
);
    import u2u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign pop_job      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `U2U8_ASSERT_ALWAYS(a_cnt_bound, count_reg <= FULL_CNT, "queue count above depth")
    `U2U8_ASSERT_IMPLY(a_no_overflow, push, !status.full || pop, "push into full queue")
    `U2U8_ASSERT_IMPLY(a_no_underflow, pop, !status.empty, "pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/u2u8_back.sv @@
`default_nettype none
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module u2u8_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire u2u8_pkg::queue_status_t q_status,
    input  wire u2u8_pkg::job_t          pop_job,
    output logic                         pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] out_byte
    output logic                         m_tlast    // last_byte
);
    import u2u8_pkg::*;

    job_t                 job_reg, job_next;
    logic                 busy_reg, busy_next;
    logic [JOB_CNT_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;

    logic out_load, emit, at_end, job_done;

    assign out_load = !out_valid_reg || m_tready;
    assign emit     = busy_reg && out_load;
    assign at_end   = (idx_reg == job_reg.count - 1'b1);
    assign job_done = emit && at_end;
    assign pop      = !q_status.empty && (!busy_reg || job_done);

    always_comb
    begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_load)
        begin
            out_valid_next = emit;
            out_byte_next  = job_reg.data[idx_reg];
            out_last_next  = job_reg.last && at_end;
        end
        if (emit)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (job_done)
        begin
            busy_next = 1'b0;
        end
        // take the next job without a gap between jobs
        if (pop)
        begin
            job_next  = pop_job;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    `U2U8_ASSERT_IMPLY(a_busy_count, busy_reg, job_reg.count != '0, "active job has no bytes")
    `U2U8_ASSERT_IMPLY(a_idx_range, busy_reg, idx_reg < job_reg.count, "byte index past job end")
    `U2U8_ASSERT_IMPLY(a_pop_idle, pop, !busy_reg || job_done, "job replaced before done")

endmodule

`default_nettype wire

@@ hdl/utf16_to_utf8_transcoder_unit.sv @@
// First byte path: job queue, then job register, then output register onto m_tdata.
// Throughput: one output byte per cycle from the back-end serializer while m_tready is
// high; a unit costs k bytes (0 to 6), a BMP unit 1 to 3, a pair 4.
// Input is taken every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset (rst_n low, asynchronous) empties the queue, drops any held high surrogate
// and clears m_tvalid.
`default_nettype none

module utf16_to_utf8_transcoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] code_unit
    input  wire logic        s_tlast,   // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // last_byte
);
    import u2u8_pkg::*;

    queue_status_t q_status;
    logic          push, pop;
    job_t          push_job, pop_job;

    u2u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    u2u8_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ sim/utf8_byte_checker.sv @@
`default_nettype none

module utf8_byte_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] code_unit
    input  wire logic        s_tlast,   // end_of_string
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] out_byte
    input  wire logic        m_tlast,   // last_byte
    output int               errors,
    output int               bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import u2u8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_beat_t;

    utf8_beat_t  utf8_expected[$];
    logic        held_valid;
    logic [9:0]  held_bits;

    initial errors = 0;

    assign bytes_pending = utf8_expected.size();

    task automatic push_byte(input logic [7:0] b);
        utf8_expected.push_back('{data: b, last: 1'b0});
    endtask

    task automatic push_replacement();
        push_byte(BYTE_EF);
        push_byte(BYTE_BF);
        push_byte(BYTE_BD);
    endtask

    task automatic encode_unit(input logic [15:0] unit, input logic eos);
        logic [20:0] cp;
        logic        is_high;
        logic        is_low;
        int          base;
        base    = utf8_expected.size();
        is_high = unit[15:10] == SURR_HIGH;
        is_low  = unit[15:10] == SURR_LOW;
        if (held_valid && is_low) begin
            cp = SUPP_BASE + {1'b0, held_bits, unit[9:0]};
            push_byte(LEAD_4 | 8'(cp[20:18]));
            push_byte(CONT | 8'(cp[17:12]));
            push_byte(CONT | 8'(cp[11:6]));
            push_byte(CONT | 8'(cp[5:0]));
            held_valid = 1'b0;
            held_bits  = '0;
        end
        else begin
            // a held high surrogate that is not followed by a low one goes out as U+FFFD
            if (held_valid) begin
                push_replacement();
                held_valid = 1'b0;
                held_bits  = '0;
            end
            if (is_high) begin
                if (eos)
                    push_replacement();
                else begin
                    held_valid = 1'b1;
                    held_bits  = unit[9:0];
                end
            end
            else if (is_low)
                push_replacement();
            else if (unit < LIM_1BYTE)
                push_byte(unit[7:0]);
            else if (unit < LIM_2BYTE) begin
                push_byte(LEAD_2 | 8'(unit[10:6]));
                push_byte(CONT | 8'(unit[5:0]));
            end
            else begin
                push_byte(LEAD_3 | 8'(unit[15:12]));
                push_byte(CONT | 8'(unit[11:6]));
                push_byte(CONT | 8'(unit[5:0]));
            end
        end
        if (eos) begin
            held_valid = 1'b0;
            held_bits  = '0;
            if (utf8_expected.size() > base)
                utf8_expected[utf8_expected.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n) begin
            held_valid = 1'b0;
            held_bits  = '0;
            utf8_expected.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (utf8_expected.size() == 0) begin
                    $display("%0t: unexpected byte %02h last %0b", $time, m_tdata, m_tlast);
                    errors = errors + 1;
                end
                else begin
                    utf8_beat_t want;
                    want = utf8_expected.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast) begin
                        $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                                 $time, want.data, want.last, m_tdata, m_tlast);
                        errors = errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                encode_unit(s_tdata, s_tlast);
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_utf16_to_utf8_transcoder_unit.sv @@
`default_nettype none

module tb_utf16_to_utf8_transcoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] code_unit
    logic        s_tlast  = 1'b0;  // end_of_string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;          // last_byte

    int errors;
    int bytes_pending;
    int cycle_count = 0;
    int gap_pct     = 15;
    int stall_pct   = 53;

    utf16_to_utf8_transcoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf8_byte_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .bytes_pending (bytes_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= $urandom_range(99) >= stall_pct;
    end

    task automatic send_unit(input logic [15:0] unit, input logic eos);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mostly well-formed text with random content, plus lone surrogates and raw noise.
    task automatic send_random_text(input int unit_count);
        int          sent;
        int          kind;
        logic [15:0] unit;
        logic        eos;
        sent = 0;
        while (sent < unit_count) begin
            kind = $urandom_range(9);
            eos  = $urandom_range(7) == 0;
            case (kind)
                0, 1: unit = 16'($urandom_range(16'h007F));
                2:    unit = 16'($urandom_range(16'h07FF, 16'h0080));
                3:    unit = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h0800))
                                               : 16'($urandom_range(16'hFFFF, 16'hE000));
                4, 5: begin
                    send_unit(16'hD800 | 16'($urandom_range(1023)), 1'b0);
                    sent = sent + 1;
                    unit = 16'hDC00 | 16'($urandom_range(1023));
                end
                6:    unit = 16'hDC00 | 16'($urandom_range(1023));
                7:    unit = 16'hD800 | 16'($urandom_range(1023));
                default: unit = 16'($urandom_range(16'hFFFF));
            endcase
            send_unit(unit, eos);
            sent = sent + 1;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // boundaries of each encoding length
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // pairs at both ends of the supplementary range
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // held high followed by a plain unit, then by another high
        send_unit(16'hD801, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD802, 1'b0);
        send_unit(16'hD803, 1'b0);
        send_unit(16'hDC05, 1'b0);
        // lone low, high at end of string
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDABC, 1'b1);
        send_unit(16'h20AC, 1'b1);
        // held high, end of string on a plain unit, a low one and a high one
        send_unit(16'hD900, 1'b0);
        send_unit(16'h0041, 1'b1);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hDE00, 1'b1);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDB00, 1'b1);

        send_random_text(78);
        gap_pct   = 53;
        stall_pct = 15;
        send_random_text(78);
        gap_pct   = 0;
        stall_pct = 0;
        send_random_text(78);
        s_tvalid <= 1'b0;

        while (bytes_pending != 0)
            @(posedge clk);
        // catch stray bytes still in the pipeline
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/u2u8_pkg.sv
hdl/u2u8_front.sv
hdl/u2u8_queue.sv
hdl/u2u8_back.sv
hdl/utf16_to_utf8_transcoder_unit.sv
sim/utf8_byte_checker.sv
sim/tb_utf16_to_utf8_transcoder_unit.sv
